FILE: src/slab_pkg.sv
// Shared constants, types and class size table of the slab size-class allocator.
package slab_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_CLASSES = 10;
    localparam int ADDR_W      = 18;
    localparam int SIZE_W      = 11;
    localparam int REQ_SIZE_W  = 20;
    localparam int CLS_W       = 4;
    localparam int PAGE_W      = 6;
    localparam int NPAGE_W     = 7;
    localparam int OFF_W       = 13;
    localparam int LINK_AW     = 15;
    localparam int LINK_DEPTH  = 32768;
    localparam int ADDR_PAGES  = 64;
    localparam int PAGE_LIMIT  = (NUM_PAGES < ADDR_PAGES) ? NUM_PAGES : ADDR_PAGES;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BIG     = 3'd1,
        ST_NO_PAGE = 3'd2,
        ST_NULL    = 3'd3,
        ST_UNOWNED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CARVE,
        S_POP,
        S_OWN
    } state_t;

    function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        logic [SIZE_W-1:0] b;
        unique case (c)
            4'd0:    b = 11'd8;
            4'd1:    b = 11'd16;
            4'd2:    b = 11'd24;
            4'd3:    b = 11'd32;
            4'd4:    b = 11'd48;
            4'd5:    b = 11'd64;
            4'd6:    b = 11'd128;
            4'd7:    b = 11'd256;
            4'd8:    b = 11'd512;
            4'd9:    b = 11'd1024;
            default: b = 11'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: src/slab_if.sv
// Request and response channel interfaces of the slab allocator.
interface slab_req_if;
    import slab_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0]     req_addr;
    modport source (output valid, req_type, req_size, req_addr, input ready);
    modport sink   (input valid, req_type, req_size, req_addr, output ready);
endinterface

interface slab_rsp_if;
    import slab_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] result_size;
    modport source (output valid, status, result_addr, result_size, input ready);
    modport sink   (input valid, status, result_addr, result_size, output ready);
endinterface

FILE: src/slab_size_class_allocator_top.sv
// Slab allocator with ten size classes: request/response top level.
//
// One request beat on req (allocate, free or size query) gives exactly one
// response beat on rsp. Beats use valid/ready; a beat moves when both are high.
// Free-list links live in a 32768 x 18 synchronous RAM, page owners in a
// 64 x 4 RAM, class heads in ten registers.
// Big, null, unowned and unused requests answer through the response register
// loaded as the beat is taken. Allocate from a nonempty class and free or
// query first pass through S_POP or S_OWN (one RAM read, then the write back).
// An allocate that finds its class empty first carves a fresh page in S_CARVE,
// one link per cycle, then goes on through S_POP.
// Throughput: one request per cycle for requests answered at once; allocate, free
// and query keep req not ready until their write back; req is ready only while
// no request is in flight and the response register is free or being drained.
// Reset: the block carves pages 0 to 9 for classes 0 to 9 first, with req
// held not ready.
// Stall: a response waits in its register until rsp.ready; req stays low
// while the register is full and not drained.
module slab_size_class_allocator_top (
    input  logic       clk,
    input  logic       rst_n,
    slab_req_if.sink   req,
    slab_rsp_if.source rsp
);
    import slab_pkg::*;

    state_t                state_reg, state_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [CLS_W-1:0]      cls_reg, cls_next;
    logic [OFF_W-1:0]      off_reg, off_next;
    addr_t                 slot_reg, slot_next;
    addr_t                 addr_reg, addr_next;
    logic [1:0]            type_reg, type_next;
    logic [NPAGE_W-1:0]    next_page_reg, next_page_next;
    logic                  ov_reg, ov_next;
    status_t               st_reg, st_next;
    addr_t                 ra_reg, ra_next;
    logic [SIZE_W-1:0]     rs_reg, rs_next;

    addr_t                 head_reg [NUM_CLASSES];
    logic                  head_we;
    logic [CLS_W-1:0]      head_wi;
    addr_t                 head_wd;

    addr_t                 link_mem [LINK_DEPTH];
    logic                  lk_we, lk_re;
    logic [LINK_AW-1:0]    lk_wa, lk_ra;
    addr_t                 lk_wd;
    addr_t                 lk_rd_reg;

    logic [CLS_W-1:0]      own_mem [ADDR_PAGES];
    logic                  own_we;
    logic [CLS_W-1:0]      own_rd_reg;

    logic                  acc;
    logic                  fit_ok;
    logic [CLS_W-1:0]      fit_cls;
    logic [PAGE_W-1:0]     req_page;
    logic [SIZE_W-1:0]     sz;
    logic [OFF_W-1:0]      nxt_off;
    logic                  last;
    addr_t                 carve_addr;
    addr_t                 fit_head;
    logic [CLS_W-1:0]      owner;
    addr_t                 owner_head;

    assign req.ready       = (state_reg == S_IDLE) && (!ov_reg || rsp.ready);
    assign acc             = req.valid && req.ready;
    assign req_page        = req.req_addr[ADDR_W-1 -: PAGE_W];
    assign rsp.valid       = ov_reg;
    assign rsp.status      = st_reg;
    assign rsp.result_addr = ra_reg;
    assign rsp.result_size = rs_reg;

    always_comb
    begin
        fit_ok  = 1'b0;
        fit_cls = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if ({9'd0, class_bytes(CLS_W'(k))} >= req.req_size)
            begin
                fit_ok  = 1'b1;
                fit_cls = CLS_W'(k);
            end
        end
    end

    assign fit_head   = head_reg[fit_cls];
    assign sz         = class_bytes(cls_reg);
    assign nxt_off    = off_reg + {2'b0, sz};
    assign last       = ({1'b0, nxt_off} + {3'b0, sz}) > 14'd4096;
    assign carve_addr = {page_reg, off_reg[11:0]};
    assign owner      = (addr_reg[ADDR_W-1 -: PAGE_W] < PAGE_W'(NUM_CLASSES))
                        ? addr_reg[ADDR_W-3 -: CLS_W] : own_rd_reg;
    assign owner_head = head_reg[owner];

    always_comb
    begin
        state_next     = state_reg;
        page_next      = page_reg;
        cls_next       = cls_reg;
        off_next       = off_reg;
        slot_next      = slot_reg;
        addr_next      = addr_reg;
        type_next      = type_reg;
        next_page_next = next_page_reg;
        ov_next        = ov_reg && !rsp.ready;
        st_next        = st_reg;
        ra_next        = ra_reg;
        rs_next        = rs_reg;
        head_we        = 1'b0;
        head_wi        = cls_reg;
        head_wd        = '0;
        lk_we          = 1'b0;
        lk_wa          = carve_addr[ADDR_W-1:3];
        lk_wd          = last ? '0 : {page_reg, nxt_off[11:0]};
        lk_re          = 1'b0;
        lk_ra          = fit_head[ADDR_W-1:3];
        own_we         = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                lk_we = 1'b1;
                if (!last)
                begin
                    off_next = nxt_off;
                end
                else
                begin
                    head_we = 1'b1;
                    head_wd = {page_reg, 1'b0, sz};
                    if (page_reg == PAGE_W'(NUM_CLASSES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        page_next = page_reg + 1'b1;
                        cls_next  = cls_reg + 1'b1;
                        off_next  = {2'b0, class_bytes(cls_reg + 1'b1)};
                    end
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    cls_next  = fit_cls;
                    addr_next = req.req_addr;
                    type_next = req.req_type;
                    unique case (req_type_t'(req.req_type))
                        REQ_ALLOC:
                        begin
                            if (!fit_ok)
                            begin
                                ov_next = 1'b1;
                                st_next = ST_BIG;
                                ra_next = '0;
                                rs_next = '0;
                            end
                            else if (fit_head == '0)
                            begin
                                if (next_page_reg >= NPAGE_W'(PAGE_LIMIT))
                                begin
                                    ov_next = 1'b1;
                                    st_next = ST_NO_PAGE;
                                    ra_next = '0;
                                    rs_next = class_bytes(fit_cls);
                                end
                                else
                                begin
                                    page_next  = next_page_reg[PAGE_W-1:0];
                                    off_next   = {2'b0, class_bytes(fit_cls)};
                                    state_next = S_CARVE;
                                end
                            end
                            else
                            begin
                                lk_re      = 1'b1;
                                slot_next  = fit_head;
                                state_next = S_POP;
                            end
                        end
                        REQ_FREE, REQ_QUERY:
                        begin
                            if (req.req_addr == '0)
                            begin
                                ov_next = 1'b1;
                                st_next = ST_NULL;
                                ra_next = '0;
                                rs_next = '0;
                            end
                            else if (req.req_addr[11:0] == 12'd0
                                     || {1'b0, req_page} >= next_page_reg)
                            begin
                                ov_next = 1'b1;
                                st_next = ST_UNOWNED;
                                ra_next = '0;
                                rs_next = '0;
                            end
                            else
                            begin
                                state_next = S_OWN;
                            end
                        end
                        REQ_NONE:
                        begin
                            ov_next = 1'b1;
                            st_next = ST_OK;
                            ra_next = '0;
                            rs_next = '0;
                        end
                    endcase
                end
            end
            S_CARVE:
            begin
                lk_we = 1'b1;
                if (!last)
                begin
                    off_next = nxt_off;
                end
                else
                begin
                    own_we         = 1'b1;
                    slot_next      = {page_reg, 1'b0, sz};
                    lk_re          = 1'b1;
                    lk_ra          = slot_next[ADDR_W-1:3];
                    next_page_next = next_page_reg + 1'b1;
                    state_next     = S_POP;
                end
            end
            S_POP:
            begin
                head_we    = 1'b1;
                head_wd    = lk_rd_reg;
                lk_we      = 1'b1;
                lk_wa      = slot_reg[ADDR_W-1:3];
                lk_wd      = '0;
                ov_next    = 1'b1;
                st_next    = ST_OK;
                ra_next    = slot_reg;
                rs_next    = sz;
                state_next = S_IDLE;
            end
            S_OWN:
            begin
                if (req_type_t'(type_reg) == REQ_FREE)
                begin
                    head_we = 1'b1;
                    head_wi = owner;
                    head_wd = addr_reg;
                    lk_we   = 1'b1;
                    lk_wa   = addr_reg[ADDR_W-1:3];
                    lk_wd   = owner_head;
                end
                ov_next    = 1'b1;
                st_next    = ST_OK;
                ra_next    = '0;
                rs_next    = class_bytes(owner);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            page_reg      <= '0;
            cls_reg       <= '0;
            off_reg       <= {2'b0, class_bytes('0)};
            next_page_reg <= NPAGE_W'(NUM_CLASSES);
            ov_reg        <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                head_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            page_reg      <= page_next;
            cls_reg       <= cls_next;
            off_reg       <= off_next;
            next_page_reg <= next_page_next;
            ov_reg        <= ov_next;
            if (head_we)
            begin
                head_reg[head_wi] <= head_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        addr_reg <= addr_next;
        type_reg <= type_next;
        st_reg   <= st_next;
        ra_reg   <= ra_next;
        rs_reg   <= rs_next;
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[lk_wa] <= lk_wd;
        end
        if (lk_re)
        begin
            lk_rd_reg <= link_mem[lk_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[page_reg] <= cls_reg;
        end
        if (acc)
        begin
            own_rd_reg <= own_mem[req_page];
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("request accepted outside idle");

    a_page_limit: assert property (@(posedge clk) disable iff (!rst_n)
        next_page_reg <= NPAGE_W'(PAGE_LIMIT))
        else $error("page counter beyond limit");

    a_rsp_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP || state_reg == S_OWN) |-> !ov_reg)
        else $error("response register busy at write back");

    a_carve_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARVE && last) |=> next_page_reg == $past(next_page_reg) + 1'b1)
        else $error("carve did not advance page counter");

endmodule
